[rtl/cqdp_pkg.sv]
// shared constants and types for the codebook dot product block
`default_nettype none

package cqdp_pkg;

    localparam int unsigned CENTROID_COUNT = 64;
    localparam int unsigned SLOT_BITS      = $clog2(CENTROID_COUNT);
    localparam int unsigned IDX_BITS       = 6;
    localparam int unsigned GROUP_SIZE     = 4;
    localparam int unsigned GROUP_BITS     = GROUP_SIZE * IDX_BITS;
    localparam int unsigned COUNT_BITS     = 3;

    localparam int unsigned VALUE_BITS     = 16;
    localparam int unsigned SUM_BITS       = 56;

    localparam int unsigned QUEUE_DEPTH    = 4;
    localparam int unsigned QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCOUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_WEIGHT = 1'b1
    } t_action;

    // decoded request as it sits in the queue
    typedef struct packed {
        logic                                is_load;
        logic [SLOT_BITS-1:0]                slot;
        logic [GROUP_SIZE-1:0][IDX_BITS-1:0] idx;
        logic [GROUP_SIZE-1:0]               lane_mask;
        logic                                last;
    } t_ctrl;

endpackage

`default_nettype wire

[rtl/cqdp_if.sv]
// request and result channel interfaces
`default_nettype none

interface cqdp_req_if #(
    parameter int unsigned VALUE_BITS = cqdp_pkg::VALUE_BITS
);
    logic                                  valid;
    logic                                  ready;
    logic                                  action;
    logic [cqdp_pkg::SLOT_BITS-1:0]        centroid_slot;
    logic signed [VALUE_BITS-1:0]          centroid_value;
    logic [cqdp_pkg::GROUP_BITS-1:0]       packed_group;
    logic signed [VALUE_BITS-1:0]          act_zero;
    logic signed [VALUE_BITS-1:0]          act_one;
    logic signed [VALUE_BITS-1:0]          act_two;
    logic signed [VALUE_BITS-1:0]          act_three;
    logic [cqdp_pkg::COUNT_BITS-1:0]       valid_count;
    logic                                  last_group;

    modport source (
        output valid, action, centroid_slot, centroid_value, packed_group,
               act_zero, act_one, act_two, act_three, valid_count, last_group,
        input  ready
    );

    modport sink (
        input  valid, action, centroid_slot, centroid_value, packed_group,
               act_zero, act_one, act_two, act_three, valid_count, last_group,
        output ready
    );
endinterface

interface cqdp_res_if #(
    parameter int unsigned SUM_BITS = cqdp_pkg::SUM_BITS
);
    logic                        valid;
    logic                        ready;
    logic signed [SUM_BITS-1:0]  dot_product;

    modport source (output valid, dot_product, input ready);
    modport sink   (input valid, dot_product, output ready);
endinterface

`default_nettype wire

[rtl/codebook_q6_dot_product.sv]
// top level of the codebook dot product block
// Takes one request per cycle while the queue has room: centroid loads
// (action 0) and weight groups (action 1) enter a four-entry queue in order
// and are drained by a five-stage back pipeline (table lookup, four
// multiplies, pair add, group add, accumulate) that puts a last group's sum
// in the output register; without stalls a group can follow every cycle. The
// centroid table is two 64-entry copies written together, each read at two
// indices per cycle; it is not cleared at reset, so entries must be loaded
// before a group refers to them. A load takes effect for every group accepted
// after it. The result sits in an output register and holds until taken;
// while it waits the pipeline stalls and the queue keeps accepting until full.
`default_nettype none

module codebook_q6_dot_product #(
    parameter int unsigned VALUE_BITS = cqdp_pkg::VALUE_BITS,
    parameter int unsigned SUM_BITS   = cqdp_pkg::SUM_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cqdp_req_if.sink    i_req,
    cqdp_res_if.source  o_res
);

    logic                                              w_head_valid;
    cqdp_pkg::t_ctrl                                   w_head_ctrl;
    logic [VALUE_BITS-1:0]                             w_head_value;
    logic [cqdp_pkg::GROUP_SIZE-1:0][VALUE_BITS-1:0]   w_head_act;
    logic                                              w_pop;

    cqdp_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head_ctrl  (w_head_ctrl),
        .o_head_value (w_head_value),
        .o_head_act   (w_head_act)
    );

    cqdp_back #(
        .VALUE_BITS (VALUE_BITS),
        .SUM_BITS   (SUM_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head_ctrl  (w_head_ctrl),
        .i_head_value (w_head_value),
        .i_head_act   (w_head_act),
        .o_pop        (w_pop),
        .o_res        (o_res)
    );

endmodule

`default_nettype wire

[rtl/cqdp_front.sv]
// front end: request decode and decoupling queue
`default_nettype none

module cqdp_front #(
    parameter int unsigned VALUE_BITS = cqdp_pkg::VALUE_BITS
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    cqdp_req_if.sink                                          i_req,
    input  logic                                              i_pop,
    output logic                                              o_head_valid,
    output cqdp_pkg::t_ctrl                                   o_head_ctrl,
    output logic [VALUE_BITS-1:0]                             o_head_value,
    output logic [cqdp_pkg::GROUP_SIZE-1:0][VALUE_BITS-1:0]   o_head_act
);

    cqdp_pkg::t_ctrl                                   w_ctrl;
    logic [cqdp_pkg::GROUP_SIZE-1:0][VALUE_BITS-1:0]   w_act;
    logic                                              w_push;
    logic                                              w_pop;

    cqdp_pkg::t_ctrl                                   r_q_ctrl  [cqdp_pkg::QUEUE_DEPTH];
    logic [VALUE_BITS-1:0]                             r_q_value [cqdp_pkg::QUEUE_DEPTH];
    logic [cqdp_pkg::GROUP_SIZE-1:0][VALUE_BITS-1:0]   r_q_act   [cqdp_pkg::QUEUE_DEPTH];

    logic [cqdp_pkg::QPTR_BITS-1:0]   r_wr_ptr, n_wr_ptr;
    logic [cqdp_pkg::QPTR_BITS-1:0]   r_rd_ptr, n_rd_ptr;
    logic [cqdp_pkg::QCOUNT_BITS-1:0] r_count,  n_count;

    // decode
    always_comb begin
        w_ctrl.is_load = (cqdp_pkg::t_action'(i_req.action) == cqdp_pkg::ACT_LOAD);
        w_ctrl.slot    = i_req.centroid_slot;
        w_ctrl.last    = i_req.last_group;
        for (int j = 0; j < cqdp_pkg::GROUP_SIZE; j++) begin
            w_ctrl.idx[j]       = i_req.packed_group[j*cqdp_pkg::IDX_BITS +: cqdp_pkg::IDX_BITS];
            w_ctrl.lane_mask[j] = (i_req.valid_count > cqdp_pkg::COUNT_BITS'(j));
        end
        w_act[0] = i_req.act_zero;
        w_act[1] = i_req.act_one;
        w_act[2] = i_req.act_two;
        w_act[3] = i_req.act_three;
    end

    assign i_req.ready  = (r_count != cqdp_pkg::QCOUNT_BITS'(cqdp_pkg::QUEUE_DEPTH));
    assign w_push       = i_req.valid && i_req.ready;
    assign o_head_valid = (r_count != '0);
    assign w_pop        = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + cqdp_pkg::QPTR_BITS'(1) : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + cqdp_pkg::QPTR_BITS'(1) : r_rd_ptr;
        unique case ({w_push, w_pop})
            2'b10:   n_count = r_count + cqdp_pkg::QCOUNT_BITS'(1);
            2'b01:   n_count = r_count - cqdp_pkg::QCOUNT_BITS'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_ctrl[r_wr_ptr]  <= w_ctrl;
            r_q_value[r_wr_ptr] <= i_req.centroid_value;
            r_q_act[r_wr_ptr]   <= w_act;
        end
    end

    assign o_head_ctrl  = r_q_ctrl[r_rd_ptr];
    assign o_head_value = r_q_value[r_rd_ptr];
    assign o_head_act   = r_q_act[r_rd_ptr];

endmodule

`default_nettype wire

[rtl/cqdp_back.sv]
// back end: centroid table, multiply and accumulate pipeline, result register
`default_nettype none

module cqdp_back #(
    parameter int unsigned VALUE_BITS = cqdp_pkg::VALUE_BITS,
    parameter int unsigned SUM_BITS   = cqdp_pkg::SUM_BITS
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_head_valid,
    input  cqdp_pkg::t_ctrl                                   i_head_ctrl,
    input  logic [VALUE_BITS-1:0]                             i_head_value,
    input  logic [cqdp_pkg::GROUP_SIZE-1:0][VALUE_BITS-1:0]   i_head_act,
    output logic                                              o_pop,
    cqdp_res_if.source                                        o_res
);

    localparam int unsigned PROD_BITS = 2 * VALUE_BITS;

    // two copies so that four lookups fit in two read ports each
    logic signed [VALUE_BITS-1:0] r_bank_lo [cqdp_pkg::CENTROID_COUNT];
    logic signed [VALUE_BITS-1:0] r_bank_hi [cqdp_pkg::CENTROID_COUNT];

    logic                               w_advance;
    logic                               w_load;
    logic                               w_weight;

    logic                               r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic                               r_a_last,  r_b_last,  r_c_last,  r_d_last;
    logic [cqdp_pkg::GROUP_SIZE-1:0]    r_a_mask;
    logic signed [VALUE_BITS-1:0]       r_a_cent [cqdp_pkg::GROUP_SIZE];
    logic signed [VALUE_BITS-1:0]       r_a_act  [cqdp_pkg::GROUP_SIZE];
    logic signed [PROD_BITS-1:0]        r_b_prod [cqdp_pkg::GROUP_SIZE];
    logic signed [SUM_BITS-1:0]         r_c_pair [2];
    logic signed [SUM_BITS-1:0]         r_d_total;

    logic signed [SUM_BITS-1:0]         r_sum, n_sum;
    logic signed [SUM_BITS-1:0]         w_new_sum;
    logic                               r_out_valid, n_out_valid;
    logic signed [SUM_BITS-1:0]         r_out;

    assign w_advance = !r_out_valid || o_res.ready;
    assign o_pop     = w_advance && i_head_valid;
    assign w_load    = o_pop && i_head_ctrl.is_load;
    assign w_weight  = o_pop && !i_head_ctrl.is_load;

    // table write and lookup
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            if (w_load) begin
                r_bank_lo[i_head_ctrl.slot] <= $signed(i_head_value);
                r_bank_hi[i_head_ctrl.slot] <= $signed(i_head_value);
            end
            r_a_cent[0] <= r_bank_lo[i_head_ctrl.idx[0]];
            r_a_cent[1] <= r_bank_lo[i_head_ctrl.idx[1]];
            r_a_cent[2] <= r_bank_hi[i_head_ctrl.idx[2]];
            r_a_cent[3] <= r_bank_hi[i_head_ctrl.idx[3]];
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_a_mask <= i_head_ctrl.lane_mask;
            for (int j = 0; j < cqdp_pkg::GROUP_SIZE; j++) begin
                r_a_act[j]  <= $signed(i_head_act[j]);
                r_b_prod[j] <= r_a_mask[j]
                             ? PROD_BITS'(r_a_cent[j]) * PROD_BITS'(r_a_act[j])
                             : '0;
            end
            r_c_pair[0] <= SUM_BITS'(r_b_prod[0]) + SUM_BITS'(r_b_prod[1]);
            r_c_pair[1] <= SUM_BITS'(r_b_prod[2]) + SUM_BITS'(r_b_prod[3]);
            r_d_total   <= r_c_pair[0] + r_c_pair[1];
            if (r_d_valid && r_d_last) begin
                r_out <= w_new_sum;
            end
        end
    end

    assign w_new_sum = r_sum + r_d_total;

    always_comb begin
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = r_d_valid && r_d_last;
            if (r_d_valid) begin
                n_sum = r_d_last ? '0 : w_new_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_a_last    <= 1'b0;
            r_b_last    <= 1'b0;
            r_c_last    <= 1'b0;
            r_d_last    <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_a_valid <= w_weight;
                r_b_valid <= r_a_valid;
                r_c_valid <= r_b_valid;
                r_d_valid <= r_c_valid;
                r_a_last  <= i_head_ctrl.last;
                r_b_last  <= r_a_last;
                r_c_last  <= r_b_last;
                r_d_last  <= r_c_last;
            end
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.dot_product = r_out;

endmodule

`default_nettype wire

[test/tb_codebook_q6_dot_product.sv]
// testbench for codebook_q6_dot_product: directed and random requests checked against a predictor
`timescale 1ns / 100ps

module tb_codebook_q6_dot_product;

    localparam int unsigned CENTROID_COUNT = cqdp_pkg::CENTROID_COUNT;
    localparam int unsigned SLOT_BITS      = cqdp_pkg::SLOT_BITS;
    localparam int unsigned IDX_BITS       = cqdp_pkg::IDX_BITS;
    localparam int unsigned GROUP_SIZE     = cqdp_pkg::GROUP_SIZE;
    localparam int unsigned GROUP_BITS     = cqdp_pkg::GROUP_BITS;
    localparam int unsigned COUNT_BITS     = cqdp_pkg::COUNT_BITS;
    localparam int unsigned VALUE_BITS     = cqdp_pkg::VALUE_BITS;
    localparam int unsigned SUM_BITS       = cqdp_pkg::SUM_BITS;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned LONG_HOLD      = 200;

    localparam logic signed [VALUE_BITS-1:0] MIN_VALUE = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] MAX_VALUE = {1'b0, {(VALUE_BITS-1){1'b1}}};

    localparam logic [IDX_BITS-1:0] SLOT_LOW  = 6'd0;
    localparam logic [IDX_BITS-1:0] SLOT_HIGH = 6'd63;
    localparam logic [IDX_BITS-1:0] SLOT_ODD  = 6'd21;
    localparam logic [IDX_BITS-1:0] SLOT_EVEN = 6'd42;

    typedef struct {
        cqdp_pkg::t_action            action;
        logic [SLOT_BITS-1:0]         slot;
        logic signed [VALUE_BITS-1:0] value;
        logic [GROUP_BITS-1:0]        group;
        logic signed [VALUE_BITS-1:0] act [GROUP_SIZE];
        logic [COUNT_BITS-1:0]        count;
        logic                         last;
    } t_request;

    logic i_clk;
    logic i_rst_n;

    cqdp_req_if req_bus ();
    cqdp_res_if res_bus ();

    codebook_q6_dot_product uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus)
    );

    logic signed [VALUE_BITS-1:0] centroid_model [CENTROID_COUNT];
    logic signed [SUM_BITS-1:0]   partial_sum;
    logic signed [SUM_BITS-1:0]   expected_sums [$];
    logic signed [SUM_BITS-1:0]   wanted_sum;

    int unsigned mismatches;
    int unsigned loads_sent;
    int unsigned groups_sent;
    int unsigned sums_checked;
    int unsigned stall_cycles;
    int unsigned hold_request;
    int unsigned hold_len;
    int unsigned rx_stall;
    bit          tx_idle_on;
    bit          rx_idle_on;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void model_request(input t_request r);
        int unsigned                    n;
        logic [IDX_BITS-1:0]            idx;
        logic signed [2*VALUE_BITS-1:0] product;
        if (r.action == cqdp_pkg::ACT_LOAD) begin
            centroid_model[r.slot] = r.value;
            loads_sent++;
            return;
        end
        groups_sent++;
        n = (r.count > GROUP_SIZE) ? GROUP_SIZE : r.count;
        for (int j = 0; j < n; j++) begin
            idx = r.group[j*IDX_BITS +: IDX_BITS];
            product = centroid_model[idx] * r.act[j];
            partial_sum = partial_sum + product;
        end
        if (r.last) begin
            expected_sums.push_back(partial_sum);
            partial_sum = '0;
        end
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] random_value();
        case ($urandom_range(0, 7))
            0:       return MIN_VALUE;
            1:       return MAX_VALUE;
            2:       return '0;
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    function automatic t_request load_request(input logic [SLOT_BITS-1:0] slot,
                                              input logic signed [VALUE_BITS-1:0] value);
        t_request r;
        r.action = cqdp_pkg::ACT_LOAD;
        r.slot   = slot;
        r.value  = value;
        r.group  = GROUP_BITS'($urandom);
        for (int j = 0; j < GROUP_SIZE; j++) r.act[j] = VALUE_BITS'($urandom);
        r.count  = COUNT_BITS'($urandom);
        r.last   = 1'($urandom);
        return r;
    endfunction

    function automatic t_request group_request(input logic [GROUP_BITS-1:0] group,
                                               input logic signed [VALUE_BITS-1:0] a0, a1, a2, a3,
                                               input logic [COUNT_BITS-1:0] count,
                                               input logic last);
        t_request r;
        r.action = cqdp_pkg::ACT_WEIGHT;
        r.slot   = SLOT_BITS'($urandom);
        r.value  = VALUE_BITS'($urandom);
        r.group  = group;
        r.act[0] = a0;
        r.act[1] = a1;
        r.act[2] = a2;
        r.act[3] = a3;
        r.count  = count;
        r.last   = last;
        return r;
    endfunction

    function automatic logic [GROUP_BITS-1:0] pack_indices(input logic [IDX_BITS-1:0] i0, i1,
                                                           i2, i3);
        return {i3, i2, i1, i0};
    endfunction

    function automatic t_request random_group(input logic [COUNT_BITS-1:0] count,
                                              input logic last);
        return group_request(GROUP_BITS'($urandom), random_value(), random_value(),
                             random_value(), random_value(), count, last);
    endfunction

    task automatic send_request(input t_request r);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 17) : 0;
        if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.action         <= r.action;
        req_bus.centroid_slot  <= r.slot;
        req_bus.centroid_value <= r.value;
        req_bus.packed_group   <= r.group;
        req_bus.act_zero       <= r.act[0];
        req_bus.act_one        <= r.act[1];
        req_bus.act_two        <= r.act[2];
        req_bus.act_three      <= r.act[3];
        req_bus.valid_count    <= r.count;
        req_bus.last_group     <= r.last;
        req_bus.valid          <= 1'b1;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        model_request(r);
    endtask

    task automatic wait_for_drain();
        req_bus.valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_table_loads();
        t_request r;
        r = load_request(SLOT_LOW, MIN_VALUE);
        r.last = 1'b1;
        send_request(r);
        send_request(load_request(SLOT_HIGH, MAX_VALUE));
        send_request(load_request(SLOT_ODD, 16'sd1));
        send_request(load_request(SLOT_EVEN, -16'sd1));
    endtask

    task automatic test_group_extremes();
        send_request(group_request(pack_indices(SLOT_LOW, SLOT_LOW, SLOT_LOW, SLOT_LOW),
                                   MIN_VALUE, MIN_VALUE, MIN_VALUE, MIN_VALUE, 3'd4, 1'b1));
        send_request(group_request(pack_indices(SLOT_HIGH, SLOT_HIGH, SLOT_HIGH, SLOT_HIGH),
                                   MIN_VALUE, MIN_VALUE, MIN_VALUE, MIN_VALUE, 3'd4, 1'b1));
        send_request(group_request(pack_indices(SLOT_HIGH, SLOT_HIGH, SLOT_HIGH, SLOT_HIGH),
                                   MAX_VALUE, MAX_VALUE, MAX_VALUE, MAX_VALUE, 3'd4, 1'b1));
        send_request(group_request(pack_indices(SLOT_LOW, SLOT_HIGH, SLOT_ODD, SLOT_EVEN),
                                   MAX_VALUE, MIN_VALUE, -16'sd1, 16'sd1, 3'd4, 1'b1));
    endtask

    task automatic test_counts();
        logic [GROUP_BITS-1:0] mix;
        mix = pack_indices(SLOT_EVEN, SLOT_ODD, SLOT_HIGH, SLOT_LOW);
        for (int c = 1; c <= 3; c++)
            send_request(group_request(mix, random_value(), random_value(), random_value(),
                                       random_value(), COUNT_BITS'(c), 1'b1));
        // zero count still closes the sum
        send_request(group_request(mix, MAX_VALUE, MAX_VALUE, MAX_VALUE, MAX_VALUE, 3'd0, 1'b1));
        send_request(group_request(mix, MIN_VALUE, MIN_VALUE, MIN_VALUE, MIN_VALUE, 3'd0, 1'b0));
        send_request(group_request(mix, MIN_VALUE, MAX_VALUE, MIN_VALUE, MAX_VALUE, 3'd2, 1'b1));
        // counts above four act as four
        for (int c = 5; c <= 7; c++)
            send_request(group_request(mix, random_value(), random_value(), random_value(),
                                       random_value(), COUNT_BITS'(c), 1'b1));
    endtask

    task automatic test_accumulate_and_reload();
        logic [GROUP_BITS-1:0] mix;
        mix = pack_indices(SLOT_ODD, SLOT_LOW, SLOT_EVEN, SLOT_HIGH);
        for (int g = 0; g < 3; g++)
            send_request(group_request(mix, random_value(), random_value(), random_value(),
                                       random_value(), 3'd4, 1'b0));
        send_request(group_request(mix, MIN_VALUE, MIN_VALUE, MIN_VALUE, MIN_VALUE, 3'd4, 1'b1));
        // a load must reach the very next group
        send_request(load_request(SLOT_ODD, 16'sh5A5A));
        send_request(group_request(pack_indices(SLOT_ODD, SLOT_ODD, SLOT_ODD, SLOT_ODD),
                                   MAX_VALUE, 16'sd3, -16'sd7, MIN_VALUE, 3'd4, 1'b1));
    endtask

    task automatic test_random_stream(input int unsigned n_requests, input bit full_reload,
                                      input bit tx_idle, input bit rx_idle);
        int unsigned start;
        int unsigned len;
        logic [COUNT_BITS-1:0] count;
        start = loads_sent + groups_sent;
        tx_idle_on = tx_idle;
        rx_idle_on = rx_idle;
        for (int s = 0; s < (full_reload ? CENTROID_COUNT : 16); s++)
            send_request(load_request(full_reload ? SLOT_BITS'(s)
                                                  : SLOT_BITS'($urandom_range(0, 63)),
                                      random_value()));
        while (loads_sent + groups_sent - start < n_requests) begin
            len = $urandom_range(1, 8);
            for (int g = 0; g < len; g++) begin
                if ($urandom_range(0, 15) == 0)
                    send_request(load_request(SLOT_BITS'($urandom_range(0, 63)),
                                              random_value()));
                if ($urandom_range(0, 15) == 0)
                    count = COUNT_BITS'($urandom_range(0, 7));
                else if (g == len - 1)
                    count = COUNT_BITS'($urandom_range(1, 4));
                else
                    count = 3'd4;
                send_request(random_group(count, (g == len - 1) || ($urandom_range(0, 19) == 0)));
            end
        end
        wait_for_drain();
    endtask

    task automatic test_result_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_request = LONG_HOLD;
        for (int g = 0; g < 24; g++)
            send_request(random_group(3'd4, g % 3 != 1));
        wait_for_drain();
    endtask

    initial begin
        res_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_len = hold_request;
                hold_request = 0;
                res_bus.ready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                res_bus.ready <= 1'b1;
            end else if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
                rx_stall = rx_idle_on ? $urandom_range(0, 17) : 0;
                if (rx_stall != 0) begin
                    res_bus.ready <= 1'b0;
                    repeat (rx_stall) @(posedge i_clk);
                    res_bus.ready <= 1'b1;
                end
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            if (expected_sums.size() == 0) begin
                report_mismatch($sformatf("dot product %0d with no sum pending",
                                          res_bus.dot_product));
            end else begin
                wanted_sum = expected_sums.pop_front();
                sums_checked++;
                if (res_bus.dot_product !== wanted_sum)
                    report_mismatch($sformatf("dot product %0d, expected %0d",
                                              res_bus.dot_product, wanted_sum));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
            (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n                <= 1'b0;
        req_bus.valid          <= 1'b0;
        req_bus.action         <= cqdp_pkg::ACT_LOAD;
        req_bus.centroid_slot  <= '0;
        req_bus.centroid_value <= '0;
        req_bus.packed_group   <= '0;
        req_bus.act_zero       <= '0;
        req_bus.act_one        <= '0;
        req_bus.act_two        <= '0;
        req_bus.act_three      <= '0;
        req_bus.valid_count    <= '0;
        req_bus.last_group     <= 1'b0;
        partial_sum  = '0;
        mismatches   = 0;
        loads_sent   = 0;
        groups_sent  = 0;
        sums_checked = 0;
        stall_cycles = 0;
        hold_request = 0;
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        for (int s = 0; s < CENTROID_COUNT; s++) centroid_model[s] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_loads();
        test_group_extremes();
        test_counts();
        test_accumulate_and_reload();
        wait_for_drain();
        test_random_stream(480, 1'b1, 1'b0, 1'b0);
        test_result_backpressure();
        test_random_stream(480, 1'b0, 1'b1, 1'b0);
        test_random_stream(480, 1'b0, 1'b0, 1'b1);
        test_random_stream(480, 1'b0, 1'b1, 1'b1);

        $display("sent %0d centroid loads and %0d weight groups, checked %0d dot products",
                 loads_sent, groups_sent, sums_checked);
        $display("covered value extremes, tail and odd counts, reloads, idle gaps, long stall");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
